FILE: rtl/pidc_pkg.sv
package pidc_pkg;

  localparam int unsigned IN_DATA_W  = 72;  // 67 bits of fields, padded to bytes
  localparam int unsigned OUT_DATA_W = 40;  // 33 bits of fields, padded to bytes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned LIM_W   = 15;
  localparam int unsigned JIDX_W  = 3;
  localparam int unsigned INTEG_W = 48;
  localparam int unsigned OPER_W  = 25;
  localparam int unsigned PROD_W  = 2 * OPER_W;
  localparam int unsigned ACC_W   = 66;
  localparam int unsigned DRIVE_W = 16;

  // fraction bits dropped between the accumulator and the drive
  localparam int unsigned ACC_FRAC = 29;
  // integral term carries 17 more fraction bits than the P and D terms
  localparam int unsigned PD_SHIFT = 17;
  localparam int unsigned HALF_W   = INTEG_W / 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P_GAIN = 2'd0,
    REG_I_GAIN = 2'd1,
    REG_D_GAIN = 2'd2,
    REG_DRIVE_LIMIT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDT,
    ST_INTEG,
    ST_PERR,
    ST_DVEL,
    ST_ILO,
    ST_IHI,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/pid_position_controller_top.sv
// Channel   Direction  Payload (lowest bit first)
// s_*       in         joint_index[2:0] goal_position[18:3] measured_position[34:19]
//                      measured_velocity[50:35] tick_dt[66:51]
// m_*       out        drive_effort[15:0] pos_error[32:16]
// cfg_*     in         register write: cfg_index selects, cfg_data carries the value
//
// A new request is not taken until the one before it is through: all five
// products (error*dt, P, D, and the integral term in two halves) go one per
// cycle through a single 25x25 multiplier with a registered product.
// s_tready is high only while the sequencer is idle.
// A finished result waits in the output register; the sequencer stalls in its
// last step while that register is still full and not taken.
// rst is synchronous; it restores the gains and clears every joint integrator.
module pid_position_controller_top
  import pidc_pkg::*;
#(
  parameter int unsigned JOINTS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // joint_index, goal_position, measured_position, measured_velocity, tick_dt
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // drive_effort, pos_error
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned IDX_W = $clog2(JOINTS > 1 ? JOINTS : 2);
  localparam int unsigned EXT_W = (IDX_W > JIDX_W) ? IDX_W : JIDX_W;
  localparam int unsigned CMP_W = EXT_W + 1;

  state_t state, state_next;

  logic [GAIN_W-1:0] p_gain, i_gain, d_gain;
  logic [LIM_W-1:0]  drive_limit;

  logic [JIDX_W-1:0]        joint;
  logic signed [ERR_W-1:0]  err;
  logic signed [POS_W-1:0]  vel;
  logic [POS_W-1:0]         dt;
  logic signed [INTEG_W-1:0] integ;
  logic signed [ACC_W-1:0]  acc;

  logic                      accept;
  logic                      joint_ok;
  logic [EXT_W-1:0]          joint_ext, in_joint_ext;
  logic [IDX_W-1:0]          rd_addr, wr_addr;
  logic signed [INTEG_W-1:0] integ_old;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_new;
  logic                      integ_wr;

  logic signed [OPER_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;

  logic signed [ACC_W-ACC_FRAC-1:0] drive_full;
  logic signed [ACC_W-ACC_FRAC-1:0] lim_pos, lim_neg;
  logic signed [DRIVE_W-1:0]        drive;
  logic                             out_load;

  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain      <= GAIN_W'(256);
      i_gain      <= '0;
      d_gain      <= '0;
      drive_limit <= '1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_P_GAIN:      p_gain      <= cfg_data;
        REG_I_GAIN:      i_gain      <= cfg_data;
        REG_D_GAIN:      d_gain      <= cfg_data;
        REG_DRIVE_LIMIT: drive_limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // integrator store
  assign in_joint_ext = EXT_W'(s_tdata[JIDX_W-1:0]);
  assign joint_ext    = EXT_W'(joint);
  assign rd_addr      = in_joint_ext[IDX_W-1:0];
  assign wr_addr      = joint_ext[IDX_W-1:0];
  assign joint_ok     = (CMP_W'(joint) < CMP_W'(JOINTS));
  assign integ_wr     = (state == ST_INTEG) && joint_ok;

  pidc_integ_store #(
    .JOINTS (JOINTS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (integ_old),
    .wr_en   (integ_wr),
    .wr_addr (wr_addr),
    .wr_data (integ_new)
  );

  // saturating integrator update; prod holds error*dt here
  always_comb begin
    integ_sum = (INTEG_W+1)'(integ_old) + (INTEG_W+1)'(prod);
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_new = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_new = integ_sum[INTEG_W-1:0];
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_EDT: begin
        mul_a = OPER_W'(err);
        mul_b = OPER_W'({1'b0, dt});
      end
      ST_INTEG: begin
        mul_a = OPER_W'({1'b0, p_gain});
        mul_b = OPER_W'(err);
      end
      ST_PERR: begin
        mul_a = OPER_W'({1'b0, d_gain});
        mul_b = OPER_W'(vel);
      end
      ST_DVEL: begin
        mul_a = OPER_W'({1'b0, i_gain});
        mul_b = OPER_W'({1'b0, integ[HALF_W-1:0]});
      end
      ST_ILO: begin
        mul_a = OPER_W'({1'b0, i_gain});
        // upper half carries the sign of the integrator
        mul_b = OPER_W'(signed'(integ[INTEG_W-1:HALF_W]));
      end
      default: ;
    endcase
  end

  pidc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign prod_ext = ACC_W'(prod);

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          joint <= s_tdata[JIDX_W-1:0];
          err   <= ERR_W'(signed'(s_tdata[18:3])) - ERR_W'(signed'(s_tdata[34:19]));
          vel   <= s_tdata[50:35];
          dt    <= s_tdata[66:51];
        end
      end
      ST_INTEG: integ <= joint_ok ? integ_new : '0;
      ST_PERR:  acc <= prod_ext <<< PD_SHIFT;
      ST_DVEL:  acc <= acc - (prod_ext <<< PD_SHIFT);
      ST_ILO:   acc <= acc + prod_ext;
      ST_IHI:   acc <= acc + (prod_ext <<< HALF_W);
      default: ;
    endcase
  end

  // drive limit
  always_comb begin
    drive_full = acc[ACC_W-1:ACC_FRAC];
    lim_pos    = (ACC_W-ACC_FRAC)'({1'b0, drive_limit});
    lim_neg    = -lim_pos;
    if (drive_full > lim_pos) begin
      drive = DRIVE_W'(lim_pos);
    end else if (drive_full < lim_neg) begin
      drive = DRIVE_W'(lim_neg);
    end else begin
      drive = DRIVE_W'(drive_full);
    end
  end

  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_EDT;
      ST_EDT:   state_next = ST_INTEG;
      ST_INTEG: state_next = ST_PERR;
      ST_PERR:  state_next = ST_DVEL;
      ST_DVEL:  state_next = ST_ILO;
      ST_ILO:   state_next = ST_IHI;
      ST_IHI:   state_next = ST_OUT;
      ST_OUT:   if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_DATA_W'({err, drive});
    end
  end

endmodule

FILE: rtl/pidc_mul.sv
module pidc_mul
  import pidc_pkg::*;
(
  input  logic                     clk,
  input  logic signed [OPER_W-1:0] a,
  input  logic signed [OPER_W-1:0] b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

FILE: rtl/pidc_integ_store.sv
module pidc_integ_store
  import pidc_pkg::*;
#(
  parameter int unsigned JOINTS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [$clog2(JOINTS > 1 ? JOINTS : 2)-1:0] rd_addr,
  output logic signed [INTEG_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [$clog2(JOINTS > 1 ? JOINTS : 2)-1:0] wr_addr,
  input  logic signed [INTEG_W-1:0] wr_data
);

  logic signed [INTEG_W-1:0] mem [JOINTS];
  logic [JOINTS-1:0]         valid;
  logic signed [INTEG_W-1:0] rd_mem;
  logic                      rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_mem <= mem[rd_addr];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_mem : '0;

endmodule

FILE: rtl/pidc_checker.sv
module pidc_checker
  import pidc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  // one request at a time: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid))
    else $error("request accepted while busy or result appeared too early");

  // the clamp is symmetric, so the most negative code never shows
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[DRIVE_W-1:0] != 16'h8000 && m_tdata[OUT_DATA_W-1:33] == '0)
    else $error("drive outside clamp range or padding set");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

endmodule

bind pid_position_controller_top pidc_checker u_pidc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import pidc_pkg::*;

  localparam int NUM_JOINTS     = 8;
  localparam int QUIET_LIMIT    = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int WINDUP_TICKS   = 64;
  localparam longint INTEG_HI   = (64'sd1 <<< 47) - 1;
  localparam longint INTEG_LO   = -(64'sd1 <<< 47);

  typedef struct {
    logic [JIDX_W-1:0]       joint;
    logic signed [POS_W-1:0] goal;
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] vel;
    logic [15:0]             dt;
  } tick_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [ERR_W-1:0]   err;
  } drive_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // joint_index, goal_position, measured_position, measured_velocity, tick_dt
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // drive_effort, pos_error
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  cfg_reg_t              cfg_index = REG_P_GAIN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the controller state
  logic [GAIN_W-1:0]         gain_p;
  logic [GAIN_W-1:0]         gain_i;
  logic [GAIN_W-1:0]         gain_d;
  logic [LIM_W-1:0]          effort_limit;
  logic signed [INTEG_W-1:0] joint_integral [NUM_JOINTS];

  drive_t pending_drives[$];
  int     mismatch_count = 0;
  bit     sender_pause = 1'b0;
  bit     receiver_pause = 1'b0;
  int     ready_hold = 0;

  pid_position_controller_top #(.JOINTS(NUM_JOINTS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // one control tick: update the joint integrator, form the clamped drive
  function automatic drive_t control_tick(tick_t t);
    longint err, integ, sum, drv, lim;
    drive_t r;
    err = longint'(t.goal) - longint'(t.pos);
    integ = 0;
    if (int'(t.joint) < NUM_JOINTS) begin
      integ = longint'(joint_integral[t.joint]) + err * longint'(t.dt);
      if (integ > INTEG_HI) integ = INTEG_HI;
      if (integ < INTEG_LO) integ = INTEG_LO;
      joint_integral[t.joint] = integ[INTEG_W-1:0];
    end
    sum = longint'(gain_p) * err - longint'(gain_d) * longint'(t.vel)
        + ((longint'(gain_i) * integ) >>> 17);
    drv = sum >>> 12;
    lim = longint'(effort_limit);
    if (drv > lim) drv = lim;
    if (drv < -lim) drv = -lim;
    r.drive = drv[DRIVE_W-1:0];
    r.err = err[ERR_W-1:0];
    return r;
  endfunction

  // leaves s_tvalid high on return so back-to-back requests need no gap
  task automatic send_tick(tick_t t);
    int gap;
    gap = sender_pause ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_DATA_W'({t.dt, t.vel, t.pos, t.goal, t.joint});
    do @(posedge clk); while (!s_tready);
    pending_drives.push_back(control_tick(t));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_gains(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                           logic [15:0] lim);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= REG_P_GAIN;
    cfg_data <= p;
    @(posedge clk);
    cfg_index <= REG_I_GAIN;
    cfg_data <= i;
    @(posedge clk);
    cfg_index <= REG_D_GAIN;
    cfg_data <= d;
    @(posedge clk);
    cfg_index <= REG_DRIVE_LIMIT;
    cfg_data <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    gain_p = p;
    gain_i = i;
    gain_d = d;
    effort_limit = lim[LIM_W-1:0];
  endtask

  function automatic tick_t make_tick(int joint, int goal, int pos, int vel, int dt);
    tick_t t;
    t.joint = JIDX_W'(joint);
    t.goal = POS_W'(goal);
    t.pos = POS_W'(pos);
    t.vel = POS_W'(vel);
    t.dt = 16'(dt);
    return t;
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 511));
      1: return 16'($urandom_range(0, 4095));
      2: return 16'($urandom);
      3: return 16'd0;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.joint = JIDX_W'($urandom_range(0, NUM_JOINTS - 1));
    t.goal = POS_W'($urandom);
    // keep many errors small so the drive is not always at the limit
    if ($urandom_range(0, 1)) t.pos = t.goal + POS_W'($urandom_range(0, 1023)) - 16'sd512;
    else t.pos = POS_W'($urandom);
    if ($urandom_range(0, 1)) t.vel = POS_W'($urandom_range(0, 255)) - 16'sd128;
    else t.vel = POS_W'($urandom);
    if ($urandom_range(0, 1)) t.dt = 16'($urandom_range(0, 1023));
    else t.dt = 16'($urandom);
    return t;
  endfunction

  // result check and receiver backpressure
  always @(posedge clk) begin : result_monitor
    drive_t got;
    drive_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.drive = m_tdata[15:0];
      got.err = m_tdata[32:16];
      if (pending_drives.size() == 0) begin
        flag_mismatch($sformatf("unexpected result drive=%0d err=%0d", got.drive, got.err));
      end else begin
        want = pending_drives.pop_front();
        if (got.drive !== want.drive)
          flag_mismatch($sformatf("drive_effort expected %0d got %0d",
                                  want.drive, got.drive));
        if (got.err !== want.err)
          flag_mismatch($sformatf("pos_error expected %0d got %0d",
                                  want.err, got.err));
      end
      ready_hold = receiver_pause ? $urandom_range(0, 19) : 0;
      if (ready_hold != 0) m_tready <= 1'b0;
    end else if (!m_tready) begin
      if (ready_hold != 0) ready_hold--;
      if (ready_hold == 0) m_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic test_reset_gains();
    int j;
    sender_pause = 1'b1;
    receiver_pause = 1'b1;
    for (j = 0; j < NUM_JOINTS; j++)
      send_tick(make_tick(j, j * 4096 - 16384, j * 1000, j * 37 - 100, j * 8000));
    send_tick(make_tick(0, 32767, -32768, 0, 65535));
    send_tick(make_tick(1, -32768, 32767, 32767, 0));
    send_tick(make_tick(2, 0, 0, -32768, 1));
  endtask

  task automatic test_clamp();
    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
    send_tick(make_tick(3, 32767, -32768, -32768, 65535));
    send_tick(make_tick(4, -32768, 32767, 32767, 65535));
    send_tick(make_tick(5, 100, 99, 0, 0));
    // top bit of the limit write is dropped
    set_gains(16'd512, 16'd0, 16'd256, 16'hFFFF);
    send_tick(make_tick(6, 32767, -32768, 0, 100));
    send_tick(make_tick(6, 5, 0, -3, 100));
    // zero limit forces zero drive
    set_gains(16'hFFFF, 16'd300, 16'hFFFF, 16'h0000);
    send_tick(make_tick(7, 32767, -32768, -32768, 65535));
    send_tick(make_tick(7, -32768, 32767, 32767, 65535));
    set_gains(16'd0, 16'd0, 16'd0, 16'd1000);
    send_tick(make_tick(0, 32767, -32768, 32767, 65535));
  endtask

  task automatic test_integrator_windup();
    int n;
    sender_pause = 1'b0;
    receiver_pause = 1'b0;
    // wind the integrator far up and down, with the derivative term pulling against it
    set_gains(16'd256, 16'd1, 16'd32768, 16'h7FFF);
    for (n = 0; n < WINDUP_TICKS; n++) send_tick(make_tick(6, 32767, -32768, 0, 65535));
    send_tick(make_tick(6, 0, 0, 32767, 65535));
    send_tick(make_tick(6, -32768, 32767, 0, 65535));
    send_tick(make_tick(6, 0, 0, 32767, 65535));
    for (n = 0; n < WINDUP_TICKS; n++) send_tick(make_tick(7, -32768, 32767, 0, 65535));
    send_tick(make_tick(7, 0, 0, -32768, 65535));
    send_tick(make_tick(7, 32767, -32768, 0, 65535));
    send_tick(make_tick(7, 0, 0, -32768, 65535));
  endtask

  task automatic test_random_ticks();
    int phase;
    int n;
    int mode;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_gains(16'd256, 16'd16, 16'd64, 16'h7FFF);
        1: set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        2: set_gains(16'd0, 16'd0, 16'd0, 16'd0);
        default: set_gains(pick_gain(), pick_gain(), pick_gain(), 16'($urandom));
      endcase
      for (n = 0; n < 120; n++) begin
        if (n % 40 == 0) begin
          mode = $urandom_range(0, 3);
          sender_pause = mode[0];
          receiver_pause = mode[1];
        end
        send_tick(random_tick());
      end
    end
  endtask

  initial begin
    int j;
    gain_p = 16'd256;
    gain_i = 16'd0;
    gain_d = 16'd0;
    effort_limit = 15'h7FFF;
    for (j = 0; j < NUM_JOINTS; j++) joint_integral[j] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_gains();
    test_clamp();
    test_integrator_windup();
    test_random_ticks();
    drain_results();
    repeat (20) @(posedge clk);
    if (pending_drives.size() != 0) flag_mismatch("results still outstanding at end");
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/pidc_pkg.sv
rtl/pidc_mul.sv
rtl/pidc_integ_store.sv
rtl/pid_position_controller_top.sv
rtl/pidc_checker.sv
test/testbench.sv
